@@ src/rsc_pkg.sv @@
// ---------------------------------------------------------------------------
// rsc_pkg: shared definitions of the solvent region classifier
// Sizes, codes and the command types of the atom and depth memories.
// ---------------------------------------------------------------------------
`default_nettype none

package rsc_pkg;

   // Table sizes.
   localparam int ATOMS = 4096;
   localparam int DEPTH = 32;
   localparam int AW    = $clog2(ATOMS);
   localparam int CW    = $clog2(ATOMS + 1);
   localparam int FW    = $clog2(DEPTH + 1);
   localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Request modes.
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_POINT = 2'd1;
   localparam logic [1:0] MODE_BOX   = 2'd2;

   // Verdict codes.
   localparam logic [1:0] VERDICT_INCLUDED = 2'd0;
   localparam logic [1:0] VERDICT_EXCLUDED = 2'd1;
   localparam logic [1:0] VERDICT_PARTIAL  = 2'd2;
   localparam logic [1:0] VERDICT_LOADED   = 2'd3;

   // Register indexes.
   localparam logic [1:0] REG_ATOM_COUNT   = 2'd0;
   localparam logic [1:0] REG_CLOSENESS    = 2'd1;
   localparam logic [1:0] REG_OUTER_RADIUS = 2'd2;

   localparam logic [17:0] CLOSENESS_RESET = 18'd65536;

   // One solute atom as stored in the table.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [23:0]        radius;
   } atom_type;

   // Access to the atom table.
   typedef struct packed {
      logic          rd;
      logic          wr;
      logic [AW-1:0] addr;
      atom_type      wdata;
   } atom_cmd_type;

   // Access to the exclusion depth table.
   typedef struct packed {
      logic          rd;
      logic          wr;
      logic [AW-1:0] addr;
      logic [FW-1:0] wdata;
   } depth_cmd_type;

endpackage

`default_nettype wire

@@ src/rsc_if.sv @@
// ---------------------------------------------------------------------------
// rsc_if: channel interfaces of the solvent region classifier
// Request, response and register write channels with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface rsc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [11:0]        atom_index;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [30:0]        size_x;
   logic [30:0]        size_y;
   logic [30:0]        size_z;
   logic [23:0]        probe_radius;

   modport source (output valid, mode, atom_index, pos_x, pos_y, pos_z,
                   size_x, size_y, size_z, probe_radius, input ready);
   modport sink   (input valid, mode, atom_index, pos_x, pos_y, pos_z,
                   size_x, size_y, size_z, probe_radius, output ready);
endinterface

interface rsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;
   logic       depth_overflow;

   modport source (output valid, verdict, depth_overflow, input ready);
   modport sink   (input valid, verdict, depth_overflow, output ready);
endinterface

interface rsc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [23:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/rsc_atom_mem.sv @@
// ---------------------------------------------------------------------------
// rsc_atom_mem: solute atom table
// Single-port synchronous memory of positions and radii, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module rsc_atom_mem (
   input  logic                  clock,
   input  rsc_pkg::atom_cmd_type cmd,
   output rsc_pkg::atom_type     rd_data
);
   import rsc_pkg::*;

   atom_type mem [ATOMS];
   atom_type rd_data_ff;

   // Write or read one entry per cycle.
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/rsc_depth_mem.sv @@
// ---------------------------------------------------------------------------
// rsc_depth_mem: per-atom exclusion depth table
// Synchronous memory with a clearing sweep after reset, one entry a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rsc_depth_mem (
   input  logic                   clock,
   input  logic                   reset,
   input  rsc_pkg::depth_cmd_type cmd,
   output logic [rsc_pkg::FW-1:0] rd_data,
   output logic                   clearing
);
   import rsc_pkg::*;

   logic [FW-1:0] mem [ATOMS];
   logic [FW-1:0] rd_data_ff;
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   // Clearing sweep control.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(ATOMS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Memory array: the sweep owns the write port while it runs.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.wr) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_busy_ff;

endmodule

`default_nettype wire

@@ src/rsc_sqrt.sv @@
// ---------------------------------------------------------------------------
// rsc_sqrt: integer square root
// Digit-by-digit root of a 64-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rsc_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] val_ff;
   logic [34:0] rem_ff;
   logic [31:0] root_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [34:0] rem_sh;
   logic [34:0] trial;

   // Bring down two bits and try the next root bit.
   assign rem_sh = {rem_ff[32:0], val_ff[63:62]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            val_ff  <= value;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            val_ff <= {val_ff[61:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[30:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

@@ src/solvent_region_classifier_unit.sv @@
// ---------------------------------------------------------------------------
// solvent_region_classifier_unit: solvent point and octree box classifier
// Classifies points and boxes against a table of up to 4096 solute atoms.
// ---------------------------------------------------------------------------
// After reset the exclusion depth table is swept to zero, during which no
// request is taken; register writes are taken at any time. One request is
// worked at a time. A query walks the used atoms through one shared 32x32
// multiplier with a registered product, reading the atom and depth tables one
// entry per visit: an excluded atom is skipped, a considered atom goes through
// the per-atom arithmetic. A box first computes its radius (three squares and a
// 32-step square root); every query then pops the stack entries not above its
// radius and computes the shell bounds. A box that records exclusions walks the
// atoms a second time to mark them.
`default_nettype none

module solvent_region_classifier_unit (
   input  logic      clock,
   input  logic      reset,
   rsc_req_if.sink   req_chan,
   rsc_rsp_if.source rsp_chan,
   rsc_csr_if.sink   csr_chan
);
   import rsc_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SIZE, ST_SQRT, ST_POP, ST_OUTER,
      ST_READ, ST_EVAL, ST_STEP, ST_PUSH, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      CL_INNER, CL_PART_INNER, CL_SHELL, CL_PART_SHELL, CL_OUTER
   } class_type;

   state_type          state_ff;
   logic [2:0]         step_ff;
   logic               pass2_ff;

   // Configuration registers.
   logic [CW-1:0]      atom_count_ff;
   logic [17:0]        closeness_ff;
   logic [23:0]        outer_ff;

   // Request payload.
   logic [1:0]         mode_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [30:0]        sx_ff, sy_ff, sz_ff;
   logic [23:0]        probe_ff;

   // Exclusion stack.
   logic [30:0]        stack_ff [DEPTH];
   logic [FW-1:0]      fill_ff;
   logic               popped_ff;

   // Query datapath registers.
   logic [63:0]        prod_ff;
   logic [63:0]        ss_ff;
   logic [30:0]        rad_ff;
   logic [63:0]        om2_ff, op2_ff;
   logic               ogt_ff;
   logic [CW-1:0]      idx_ff;
   logic [32:0]        dxa_ff, dya_ff, dza_ff;
   logic [24:0]        rs_ff;
   logic [66:0]        acc_ff;
   logic [26:0]        inner_ff;
   logic               kgt_ff;
   logic [63:0]        km2_ff;

   // Query flags.
   logic               any_inner_ff, any_pi_ff, any_shell_ff, any_ps_ff, any_own_ff;
   logic               ovf_ff;

   // Response register.
   logic               rsp_valid_ff;
   logic [1:0]         rsp_verdict_ff;
   logic               rsp_ovf_ff;

   // Combinational signals.
   logic               req_xfer;
   logic               rsp_load;
   logic [CW-1:0]      n_used;
   logic [FW-1:0]      fill_m1;
   logic               pop_hit;
   logic               pass_end;
   logic               last_step;
   logic [31:0]        mul_a, mul_b;
   atom_type           atom_rd;
   logic [FW-1:0]      dep_rd;
   logic               clr_hit, considered;
   logic signed [32:0] dx, dy, dz;
   logic               sq_hi;
   logic [31:0]        sq_al;
   logic [66:0]        sq_term;
   logic [26:0]        inner_now;
   logic [31:0]        km, kp, om, op;
   logic               c_inner, c_pi, c_shell, c_ps;
   class_type          cls;
   logic               own;
   logic               p_inner, p_near;
   logic [1:0]         verdict;
   atom_cmd_type       atom_cmd;
   depth_cmd_type      depth_cmd;
   logic               clearing;
   logic               sqrt_start, sqrt_done;
   logic [31:0]        sqrt_root;

   // Memories and the root unit.
   rsc_atom_mem u_atom_mem (
      .clock   (clock),
      .cmd     (atom_cmd),
      .rd_data (atom_rd)
   );

   rsc_depth_mem u_depth_mem (
      .clock    (clock),
      .reset    (reset),
      .cmd      (depth_cmd),
      .rd_data  (dep_rd),
      .clearing (clearing)
   );

   assign sqrt_start = (state_ff == ST_SIZE) && (step_ff == 3'd3);

   rsc_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (ss_ff + prod_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   // Handshake and bookkeeping.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.verdict        = rsp_verdict_ff;
   assign rsp_chan.depth_overflow = rsp_ovf_ff;

   // A finished request enters the response register once it is free.
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign n_used   = (atom_count_ff > CW'(ATOMS)) ? CW'(ATOMS) : atom_count_ff;
   assign fill_m1  = fill_ff - 1'b1;
   assign pop_hit  = (fill_ff != '0) && (rad_ff >= stack_ff[fill_m1[SW-1:0]]);
   assign pass_end = ((idx_ff + 1'b1) == n_used);
   assign last_step = (mode_ff == MODE_BOX) ? (step_ff == 3'd6) : (step_ff == 3'd5);

   // Depth seen by this pass; entries above the popped fill count as clear.
   assign clr_hit    = !pass2_ff && popped_ff && (dep_rd > fill_ff);
   assign considered = (dep_rd == '0) || clr_hit;

   // Coordinate differences of the atom just read.
   assign dx = {px_ff[31], px_ff} - {atom_rd.x[31], atom_rd.x};
   assign dy = {py_ff[31], py_ff} - {atom_rd.y[31], atom_rd.y};
   assign dz = {pz_ff[31], pz_ff} - {atom_rd.z[31], atom_rd.z};

   // Square of a 33-bit magnitude from the low 32-bit product.
   always_comb begin
      case (step_ff)
         3'd2:    begin sq_hi = dya_ff[32]; sq_al = dya_ff[31:0]; end
         3'd3:    begin sq_hi = dza_ff[32]; sq_al = dza_ff[31:0]; end
         default: begin sq_hi = dxa_ff[32]; sq_al = dxa_ff[31:0]; end
      endcase
      sq_term = {3'b000, prod_ff};
      if (sq_hi) begin
         sq_term = sq_term + {2'b00, sq_al, 33'd0} + {3'b001, 64'd0};
      end
   end

   // Radius bounds; a distance d = floor(sqrt(d2)) is below k exactly when d2 < k*k.
   assign inner_now = prod_ff[42:16];
   assign km = 32'(inner_now) - 32'(rad_ff);
   assign kp = 32'(inner_ff) + 32'(rad_ff);
   assign om = 32'(outer_ff) - 32'(rad_ff);
   assign op = 32'(outer_ff) + 32'(rad_ff);

   // Box classes of the current atom.
   assign c_inner = kgt_ff && (acc_ff < {3'b000, km2_ff});
   assign c_pi    = acc_ff < {3'b000, prod_ff};
   assign c_shell = (outer_ff == '0) || (ogt_ff && (acc_ff < {3'b000, om2_ff}));
   assign c_ps    = acc_ff < {3'b000, op2_ff};

   always_comb begin
      if (c_inner) begin
         cls = CL_INNER;
      end else if (c_pi) begin
         cls = CL_PART_INNER;
      end else if (c_shell) begin
         cls = CL_SHELL;
      end else if (c_ps) begin
         cls = CL_PART_SHELL;
      end else begin
         cls = CL_OUTER;
      end
   end

   assign own = (outer_ff != '0) ? (cls == CL_OUTER) : (cls == CL_SHELL);

   // Point tests of the current atom.
   assign p_inner = acc_ff < {3'b000, prod_ff};
   assign p_near  = acc_ff < {3'b000, op2_ff};

   // Operands of the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SIZE: begin
            case (step_ff)
               3'd0:    begin mul_a = 32'(sx_ff); mul_b = 32'(sx_ff); end
               3'd1:    begin mul_a = 32'(sy_ff); mul_b = 32'(sy_ff); end
               3'd2:    begin mul_a = 32'(sz_ff); mul_b = 32'(sz_ff); end
               default: ;
            endcase
         end
         ST_OUTER: begin
            case (step_ff)
               3'd0:    begin mul_a = om; mul_b = om; end
               3'd1:    begin mul_a = op; mul_b = op; end
               default: ;
            endcase
         end
         ST_STEP: begin
            case (step_ff)
               3'd0: begin mul_a = dxa_ff[31:0]; mul_b = dxa_ff[31:0]; end
               3'd1: begin mul_a = dya_ff[31:0]; mul_b = dya_ff[31:0]; end
               3'd2: begin mul_a = dza_ff[31:0]; mul_b = dza_ff[31:0]; end
               3'd3: begin mul_a = 32'(rs_ff); mul_b = 32'(closeness_ff); end
               3'd4: begin
                  if (mode_ff == MODE_BOX) begin
                     mul_a = km;
                     mul_b = km;
                  end else begin
                     mul_a = 32'(inner_now);
                     mul_b = 32'(inner_now);
                  end
               end
               3'd5: begin mul_a = kp; mul_b = kp; end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // Atom table access: loads on transfer, reads during the walk.
   always_comb begin
      atom_cmd.rd           = (state_ff == ST_READ);
      atom_cmd.wr           = req_xfer && (req_chan.mode == MODE_LOAD) &&
                              ({1'b0, req_chan.atom_index} < 13'(ATOMS));
      atom_cmd.addr         = (state_ff == ST_READ) ? idx_ff[AW-1:0]
                                                    : req_chan.atom_index[AW-1:0];
      atom_cmd.wdata.x      = req_chan.pos_x;
      atom_cmd.wdata.y      = req_chan.pos_y;
      atom_cmd.wdata.z      = req_chan.pos_z;
      atom_cmd.wdata.radius = req_chan.probe_radius;
   end

   // Depth table access: clear stale depths, then mark the new exclusions.
   always_comb begin
      depth_cmd.rd    = (state_ff == ST_READ);
      depth_cmd.wr    = 1'b0;
      depth_cmd.addr  = idx_ff[AW-1:0];
      depth_cmd.wdata = '0;
      if (state_ff == ST_EVAL) begin
         depth_cmd.wr = clr_hit;
      end else if (state_ff == ST_STEP && last_step && pass2_ff && own) begin
         depth_cmd.wr    = 1'b1;
         depth_cmd.wdata = fill_ff;
      end
   end

   // Verdict from the collected flags.
   always_comb begin
      case (mode_ff)
         MODE_LOAD: verdict = VERDICT_LOADED;
         MODE_POINT: begin
            if (any_inner_ff) begin
               verdict = VERDICT_EXCLUDED;
            end else if (outer_ff == '0 || any_shell_ff) begin
               verdict = VERDICT_INCLUDED;
            end else begin
               verdict = VERDICT_EXCLUDED;
            end
         end
         MODE_BOX: begin
            if (any_inner_ff) begin
               verdict = VERDICT_EXCLUDED;
            end else if (any_pi_ff) begin
               verdict = VERDICT_PARTIAL;
            end else if (any_shell_ff) begin
               verdict = VERDICT_INCLUDED;
            end else if (any_ps_ff) begin
               verdict = VERDICT_PARTIAL;
            end else begin
               verdict = VERDICT_EXCLUDED;
            end
         end
         default: verdict = VERDICT_INCLUDED;
      endcase
   end

   // Sequencer, datapath registers and response register.
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      if (reset) begin
         state_ff      <= ST_CLEAR;
         step_ff       <= '0;
         pass2_ff      <= 1'b0;
         atom_count_ff <= '0;
         closeness_ff  <= CLOSENESS_RESET;
         outer_ff      <= '0;
         fill_ff       <= '0;
         popped_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         any_inner_ff  <= 1'b0;
         any_pi_ff     <= 1'b0;
         any_shell_ff  <= 1'b0;
         any_ps_ff     <= 1'b0;
         any_own_ff    <= 1'b0;
         ovf_ff        <= 1'b0;
      end else begin
         // Register writes.
         if (csr_chan.valid && csr_chan.ready) begin
            unique case (csr_chan.index)
               REG_ATOM_COUNT:   atom_count_ff <= csr_chan.data[CW-1:0];
               REG_CLOSENESS:    closeness_ff  <= csr_chan.data[17:0];
               REG_OUTER_RADIUS: outer_ff      <= csr_chan.data;
               default: ;
            endcase
         end

         // The response register takes a finished result and drains on a transfer.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               if (!clearing) begin
                  state_ff <= ST_IDLE;
               end
            end

            ST_IDLE: begin
               if (req_xfer) begin
                  mode_ff      <= req_chan.mode;
                  px_ff        <= req_chan.pos_x;
                  py_ff        <= req_chan.pos_y;
                  pz_ff        <= req_chan.pos_z;
                  sx_ff        <= req_chan.size_x;
                  sy_ff        <= req_chan.size_y;
                  sz_ff        <= req_chan.size_z;
                  probe_ff     <= req_chan.probe_radius;
                  rad_ff       <= '0;
                  step_ff      <= '0;
                  pass2_ff     <= 1'b0;
                  popped_ff    <= 1'b0;
                  any_inner_ff <= 1'b0;
                  any_pi_ff    <= 1'b0;
                  any_shell_ff <= 1'b0;
                  any_ps_ff    <= 1'b0;
                  any_own_ff   <= 1'b0;
                  ovf_ff       <= 1'b0;
                  case (req_chan.mode)
                     MODE_POINT: state_ff <= ST_POP;
                     MODE_BOX:   state_ff <= ST_SIZE;
                     default:    state_ff <= ST_DONE;
                  endcase
               end
            end

            // Sum of the squared edge lengths, then the root.
            ST_SIZE: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == 3'd1) begin
                  ss_ff <= prod_ff;
               end else if (step_ff == 3'd2) begin
                  ss_ff <= ss_ff + prod_ff;
               end else if (step_ff == 3'd3) begin
                  state_ff <= ST_SQRT;
               end
            end

            ST_SQRT: begin
               if (sqrt_done) begin
                  rad_ff   <= sqrt_root[31:1];
                  state_ff <= ST_POP;
               end
            end

            // Pop every stacked radius not above the query radius.
            ST_POP: begin
               if (pop_hit) begin
                  fill_ff   <= fill_m1;
                  popped_ff <= 1'b1;
               end else begin
                  step_ff  <= '0;
                  state_ff <= ST_OUTER;
               end
            end

            // Squared shell bounds.
            ST_OUTER: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == 3'd1) begin
                  om2_ff <= prod_ff;
               end else if (step_ff == 3'd2) begin
                  op2_ff <= prod_ff;
                  ogt_ff <= {8'd0, outer_ff} > 32'(rad_ff);
                  idx_ff <= '0;
                  state_ff <= (n_used == '0) ? ST_PUSH : ST_READ;
               end
            end

            ST_READ: begin
               state_ff <= ST_EVAL;
            end

            ST_EVAL: begin
               if (considered) begin
                  dxa_ff   <= dx[32] ? 33'(-dx) : 33'(dx);
                  dya_ff   <= dy[32] ? 33'(-dy) : 33'(dy);
                  dza_ff   <= dz[32] ? 33'(-dz) : 33'(dz);
                  rs_ff    <= 25'(atom_rd.radius) + 25'(probe_ff);
                  step_ff  <= '0;
                  state_ff <= ST_STEP;
               end else if (pass_end) begin
                  state_ff <= ST_PUSH;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_READ;
               end
            end

            // Per-atom arithmetic on the shared multiplier.
            ST_STEP: begin
               step_ff <= step_ff + 1'b1;
               case (step_ff)
                  3'd1: acc_ff <= sq_term;
                  3'd2: acc_ff <= acc_ff + sq_term;
                  3'd3: acc_ff <= acc_ff + sq_term;
                  3'd4: begin
                     inner_ff <= inner_now;
                     kgt_ff   <= 32'(inner_now) > 32'(rad_ff);
                  end
                  3'd5: km2_ff <= prod_ff;
                  default: ;
               endcase
               if (last_step) begin
                  if (!pass2_ff) begin
                     if (mode_ff == MODE_BOX) begin
                        any_inner_ff <= any_inner_ff || (cls == CL_INNER);
                        any_pi_ff    <= any_pi_ff || (cls == CL_PART_INNER);
                        any_shell_ff <= any_shell_ff || (cls == CL_SHELL);
                        any_ps_ff    <= any_ps_ff || (cls == CL_PART_SHELL);
                        any_own_ff   <= any_own_ff || own;
                     end else begin
                        any_inner_ff <= any_inner_ff || p_inner;
                        any_shell_ff <= any_shell_ff || p_near;
                     end
                  end
                  if (pass_end) begin
                     state_ff <= ST_PUSH;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= ST_READ;
                  end
               end
            end

            // After the first walk of a box, record its own exclusions.
            ST_PUSH: begin
               if (pass2_ff || mode_ff != MODE_BOX || any_inner_ff || !any_own_ff) begin
                  state_ff <= ST_DONE;
               end else if (fill_ff == FW'(DEPTH)) begin
                  ovf_ff   <= 1'b1;
                  state_ff <= ST_DONE;
               end else begin
                  stack_ff[fill_ff[SW-1:0]] <= rad_ff;
                  fill_ff  <= fill_ff + 1'b1;
                  pass2_ff <= 1'b1;
                  idx_ff   <= '0;
                  state_ff <= ST_READ;
               end
            end

            // Hand the result to the response register once it is free.
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_verdict_ff <= verdict;
                  rsp_ovf_ff     <= ovf_ff;
                  state_ff       <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // The stack never holds more than its depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(DEPTH))
      else $error("exclusion stack fill beyond depth");

   // A finished query reaches the response register in the next cycle when it is free.
   a_done_lands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("result not handed to response register");

   // No request is taken while the depth table is being swept.
   a_clear_hold: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_chan.ready)
      else $error("request taken during depth clearing");

endmodule

`default_nettype wire
